@@ sv/directory_entry_sorter_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Directory entry sorter assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef DIRECTORY_ENTRY_SORTER_UNIT_DEFINES_SVH
`define DIRECTORY_ENTRY_SORTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/des_pkg.sv @@
// ---------------------------------------------------------------------------
// Directory entry sorter package
// Record type, cell operations, sort settings and the record compare.
// ---------------------------------------------------------------------------
package des_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int NAME_BYTES  = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int NAME_W      = 256;
    localparam int NUM_W       = 63;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SORT_KEY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENDING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_GROUPING = 2'd2;

    localparam logic [1:0] KEY_NAME  = 2'd0;
    localparam logic [1:0] KEY_SIZE  = 2'd1;
    localparam logic [1:0] KEY_MTIME = 2'd2;

    localparam logic [1:0] GROUP_DIRS_FIRST = 2'd1;
    localparam logic [1:0] GROUP_DIRS_LAST  = 2'd2;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [NUM_W-1:0]  size;
        logic [NUM_W-1:0]  mtime;
        logic              dir;
    } rec_t;

    typedef struct packed {
        logic [1:0] sort_key;
        logic       descending;
        logic [1:0] dir_grouping;
    } sort_cfg_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_TAKE_LEFT,
        OP_TAKE_RIGHT
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_DRAIN
    } des_state_t;

    // Zero every byte from the first zero byte on, and past NAME_BYTES.
    function automatic logic [NAME_W-1:0] mask_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic [7:0]        byte_v;
        logic              ended;
        res   = '0;
        ended = 1'b0;
        for (int b = 0; b < NAME_W / 8; b++)
        begin
            byte_v = raw[NAME_W - 1 - 8 * b -: 8];
            if (b >= NAME_BYTES || byte_v == 8'd0)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                res[NAME_W - 1 - 8 * b -: 8] = byte_v;
            end
        end
        return res;
    endfunction

    // True when record a must come after record b.
    function automatic logic rec_after(input rec_t a, input rec_t b, input sort_cfg_t cfg);
        logic kgt;
        logic klt;
        logic res;
        unique case (cfg.sort_key)
            KEY_NAME:
            begin
                kgt = a.name > b.name;
                klt = a.name < b.name;
            end
            KEY_SIZE:
            begin
                kgt = a.size > b.size;
                klt = a.size < b.size;
            end
            KEY_MTIME:
            begin
                kgt = a.mtime > b.mtime;
                klt = a.mtime < b.mtime;
            end
            default:
            begin
                kgt = 1'b0;
                klt = 1'b0;
            end
        endcase
        res = cfg.descending ? klt : kgt;
        // grouping wins over the key and ignores descending
        if (a.dir != b.dir)
        begin
            if (cfg.dir_grouping == GROUP_DIRS_FIRST)
            begin
                res = !a.dir;
            end
            else if (cfg.dir_grouping == GROUP_DIRS_LAST)
            begin
                res = a.dir;
            end
        end
        return res;
    endfunction

endpackage

@@ sv/directory_entry_sorter_unit.sv @@
// ---------------------------------------------------------------------------
// Directory entry sorter
// Collects directory records and sends them back sorted on the last one.
// ---------------------------------------------------------------------------
// Records are taken one per cycle into a row of MAX_ENTRIES cells, in arrival
// order. The record flagged last_entry closes the set: the row then runs n
// odd-even exchange phases (n = records held, one phase per cycle, each cell
// comparing with its right neighbor), and then shifts the sorted records out
// through cell 0, one result per cycle while out_stall is low. in_stall is
// high during sorting and sending. Equal keys keep their arrival order.
// Records beyond MAX_ENTRIES are dropped and overflow is raised on every
// result of the set. Sort settings are sampled during the sort phases.
module directory_entry_sorter_unit
    import des_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [63:0]           name_word0,
    input  logic [63:0]           name_word1,
    input  logic [63:0]           name_word2,
    input  logic [63:0]           name_word3,
    input  logic [NUM_W-1:0]      entry_size,
    input  logic [NUM_W-1:0]      entry_mtime,
    input  logic                  is_directory,
    input  logic                  last_entry,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [63:0]           out_name_word0,
    output logic [63:0]           out_name_word1,
    output logic [63:0]           out_name_word2,
    output logic [63:0]           out_name_word3,
    output logic [NUM_W-1:0]      out_size,
    output logic [NUM_W-1:0]      out_mtime,
    output logic                  out_is_directory,
    output logic                  out_last,
    output logic                  overflow
);

    des_state_t       state_reg;
    des_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] phase_reg;
    logic [CNT_W-1:0] phase_next;
    logic             overflow_reg;
    logic             overflow_next;
    sort_cfg_t        cfg_reg;

    rec_t             load_rec;
    rec_t             cell_rec [MAX_ENTRIES];
    logic             gt       [MAX_ENTRIES];
    logic             swap     [MAX_ENTRIES-1];
    cell_op_t         op       [MAX_ENTRIES];

    logic             in_acc;
    logic             out_acc;
    logic             full;

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SORT_KEY:     cfg_reg.sort_key     <= cfg_data;
                REG_DESCENDING:   cfg_reg.descending   <= cfg_data[0];
                REG_DIR_GROUPING: cfg_reg.dir_grouping <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Handshake and incoming record
    // -----------------------------------------------------------------------
    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = (state_reg == ST_DRAIN);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign full      = (count_reg == CNT_W'(MAX_ENTRIES));

    assign load_rec.name  = mask_name({name_word0, name_word1, name_word2, name_word3});
    assign load_rec.size  = entry_size;
    assign load_rec.mtime = entry_mtime;
    assign load_rec.dir   = is_directory;

    // -----------------------------------------------------------------------
    // Control state machine
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            phase_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            overflow_reg <= overflow_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_entry)
                    begin
                        phase_next = '0;
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT:
            begin
                phase_next = phase_reg + CNT_W'(1);
                if (phase_reg == count_reg - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_acc)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        overflow_next = 1'b0;
                        state_next    = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Cell operations: load at the fill point, exchange pairs, shift out
    // -----------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES - 1; i++)
        begin
            swap[i] = (state_reg == ST_SORT)
                      && (IDX_W'(i) % 2 == IDX_W'(phase_reg[0]))
                      && (CNT_W'(i + 1) < count_reg)
                      && gt[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            op[i] = OP_HOLD;
        end
        unique case (state_reg)
            ST_LOAD:
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (in_acc && !full && count_reg[IDX_W-1:0] == IDX_W'(i))
                    begin
                        op[i] = OP_LOAD;
                    end
                end
            end
            ST_SORT:
            begin
                for (int i = 0; i < MAX_ENTRIES - 1; i++)
                begin
                    if (swap[i])
                    begin
                        op[i]     = OP_TAKE_RIGHT;
                        op[i + 1] = OP_TAKE_LEFT;
                    end
                end
            end
            ST_DRAIN:
            begin
                // advance the row toward cell 0
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (out_acc)
                    begin
                        op[i] = OP_TAKE_RIGHT;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    op[i] = OP_HOLD;
                end
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Row of cells
    // -----------------------------------------------------------------------
    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            des_cell u_cell (
                .clk       (clk),
                .op        (op[g]),
                .load_rec  (load_rec),
                .left_rec  (load_rec),
                .right_rec (cell_rec[g + 1]),
                .cfg       (cfg_reg),
                .rec       (cell_rec[g]),
                .gt_right  (gt[g])
            );
        end
        else if (g == MAX_ENTRIES - 1)
        begin : g_last
            des_cell u_cell (
                .clk       (clk),
                .op        (op[g]),
                .load_rec  (load_rec),
                .left_rec  (cell_rec[g - 1]),
                .right_rec (load_rec),
                .cfg       (cfg_reg),
                .rec       (cell_rec[g]),
                .gt_right  (gt[g])
            );
        end
        else
        begin : g_mid
            des_cell u_cell (
                .clk       (clk),
                .op        (op[g]),
                .load_rec  (load_rec),
                .left_rec  (cell_rec[g - 1]),
                .right_rec (cell_rec[g + 1]),
                .cfg       (cfg_reg),
                .rec       (cell_rec[g]),
                .gt_right  (gt[g])
            );
        end
    end

    // -----------------------------------------------------------------------
    // Result fields come straight from cell 0
    // -----------------------------------------------------------------------
    assign out_name_word0   = cell_rec[0].name[255:192];
    assign out_name_word1   = cell_rec[0].name[191:128];
    assign out_name_word2   = cell_rec[0].name[127:64];
    assign out_name_word3   = cell_rec[0].name[63:0];
    assign out_size         = cell_rec[0].size;
    assign out_mtime        = cell_rec[0].mtime;
    assign out_is_directory = cell_rec[0].dir;
    assign out_last         = (count_reg == CNT_W'(1));
    assign overflow         = overflow_reg;

endmodule

@@ sv/des_cell.sv @@
// ---------------------------------------------------------------------------
// Directory entry sorter cell
// Holds one record, loads, swaps with a neighbor or shifts toward the output.
// ---------------------------------------------------------------------------
module des_cell
    import des_pkg::*;
(
    input  logic      clk,
    input  cell_op_t  op,
    input  rec_t      load_rec,
    input  rec_t      left_rec,
    input  rec_t      right_rec,
    input  sort_cfg_t cfg,
    output rec_t      rec,
    output logic      gt_right
);

    rec_t rec_reg;
    rec_t rec_next;

    always_comb
    begin
        unique case (op)
            OP_HOLD:       rec_next = rec_reg;
            OP_LOAD:       rec_next = load_rec;
            OP_TAKE_LEFT:  rec_next = left_rec;
            OP_TAKE_RIGHT: rec_next = right_rec;
            default:       rec_next = rec_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec      = rec_reg;
    assign gt_right = rec_after(rec_reg, right_rec, cfg);

endmodule

@@ sv/des_checker.sv @@
// ---------------------------------------------------------------------------
// Directory entry sorter port checker
// Watches the top-level ports for sequencing errors between load and send.
// ---------------------------------------------------------------------------
`include "directory_entry_sorter_unit_defines.svh"

module des_checker
    import des_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  last_entry,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [63:0]           out_name_word0,
    input logic [NUM_W-1:0]      out_size,
    input logic                  out_last
);

    // no new request may enter while results are being sent
    `DES_ASSERT_NOW(a_no_load_while_send, out_valid, in_stall, "request taken during send")

    // closing record starts the sort, so the input must stall next
    `DES_ASSERT_NEXT(a_sort_after_last, in_valid && !in_stall && last_entry, in_stall,
        "input not stalled after last record")

    // the final result ends the send
    `DES_ASSERT_NEXT(a_idle_after_final, out_valid && !out_stall && out_last, !out_valid,
        "results continue past final record")

    // a stalled result holds
    `DES_ASSERT_NEXT(a_result_holds, out_valid && out_stall,
        out_valid && $stable(out_name_word0) && $stable(out_size) && $stable(out_last),
        "stalled result changed")

endmodule

bind directory_entry_sorter_unit des_checker u_des_checker (.*);

@@ bench/des_result_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Directory entry sorter result checker
// Watches the register port and both request channels, keeps its own copy
// of the held records and sort settings, and compares each sorted result
// field by field with the order it works out for the set.
// ---------------------------------------------------------------------------
module des_result_checker
    import des_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [63:0]           name_word0,
    input  logic [63:0]           name_word1,
    input  logic [63:0]           name_word2,
    input  logic [63:0]           name_word3,
    input  logic [NUM_W-1:0]      entry_size,
    input  logic [NUM_W-1:0]      entry_mtime,
    input  logic                  is_directory,
    input  logic                  last_entry,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [63:0]           out_name_word0,
    input  logic [63:0]           out_name_word1,
    input  logic [63:0]           out_name_word2,
    input  logic [63:0]           out_name_word3,
    input  logic [NUM_W-1:0]      out_size,
    input  logic [NUM_W-1:0]      out_mtime,
    input  logic                  out_is_directory,
    input  logic                  out_last,
    input  logic                  overflow,
    output int                    fail_count,
    output int                    pending_results,
    output int                    results_checked,
    output int                    overflow_results
);

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [NUM_W-1:0]  size;
        logic [NUM_W-1:0]  mtime;
        logic              dir;
    } dir_entry_t;

    typedef struct packed {
        dir_entry_t ent;
        logic       last;
        logic       ovf;
    } sorted_entry_t;

    sort_cfg_t     mode;
    dir_entry_t    held[$];
    logic          drop_seen;
    sorted_entry_t sorted_q[$];

    // Clear every byte from the first zero byte on.
    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
        int                first_zero;
        logic [NAME_W-1:0] keep_mask;
        first_zero = NAME_W / 8;
        for (int b = NAME_W / 8 - 1; b >= 0; b--)
        begin
            if (raw[NAME_W - 1 - 8 * b -: 8] == 8'd0)
            begin
                first_zero = b;
            end
        end
        if (first_zero > NAME_BYTES)
        begin
            first_zero = NAME_BYTES;
        end
        keep_mask = ~({NAME_W{1'b1}} >> (8 * first_zero));
        return raw & keep_mask;
    endfunction

    function automatic int key_order(input dir_entry_t a, input dir_entry_t b);
        int ord;
        ord = 0;
        case (mode.sort_key)
            KEY_NAME:
            begin
                ord = (a.name > b.name) ? 1 : ((a.name < b.name) ? -1 : 0);
            end
            KEY_SIZE:
            begin
                ord = (a.size > b.size) ? 1 : ((a.size < b.size) ? -1 : 0);
            end
            KEY_MTIME:
            begin
                ord = (a.mtime > b.mtime) ? 1 : ((a.mtime < b.mtime) ? -1 : 0);
            end
            default:
            begin
                ord = 0;
            end
        endcase
        return mode.descending ? -ord : ord;
    endfunction

    // Grouping decides first and is not reversed by descending.
    function automatic bit must_follow(input dir_entry_t a, input dir_entry_t b);
        if (a.dir != b.dir)
        begin
            if (mode.dir_grouping == GROUP_DIRS_FIRST)
            begin
                return !a.dir;
            end
            if (mode.dir_grouping == GROUP_DIRS_LAST)
            begin
                return a.dir;
            end
        end
        return key_order(a, b) > 0;
    endfunction

    // Stable insertion sort of the held set into the expected result order.
    task automatic release_set();
        dir_entry_t    order [MAX_ENTRIES];
        sorted_entry_t res;
        int            n;
        int            j;
        n = held.size();
        for (int i = 0; i < n; i++)
        begin
            j = i;
            while (j > 0 && must_follow(order[j - 1], held[i]))
            begin
                order[j] = order[j - 1];
                j--;
            end
            order[j] = held[i];
        end
        for (int i = 0; i < n; i++)
        begin
            res.ent  = order[i];
            res.last = (i == n - 1);
            res.ovf  = drop_seen;
            sorted_q.push_back(res);
        end
        held.delete();
        drop_seen = 1'b0;
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, actual %h", fname, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sorted_entry_t exp_r;
        dir_entry_t    ent;
        if (!rst_n)
        begin
            mode             = '0;
            drop_seen        = 1'b0;
            held.delete();
            sorted_q.delete();
            fail_count       = 0;
            pending_results  = 0;
            results_checked  = 0;
            overflow_results = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SORT_KEY:     mode.sort_key     = cfg_data[1:0];
                    REG_DESCENDING:   mode.descending   = cfg_data[0];
                    REG_DIR_GROUPING: mode.dir_grouping = cfg_data[1:0];
                    default:          ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (sorted_q.size() == 0)
                begin
                    $error("out_name_word0: expected no result, actual %h", out_name_word0);
                    fail_count++;
                end
                else
                begin
                    exp_r = sorted_q.pop_front();
                    check_field("out_name_word0", exp_r.ent.name[255:192], out_name_word0);
                    check_field("out_name_word1", exp_r.ent.name[191:128], out_name_word1);
                    check_field("out_name_word2", exp_r.ent.name[127:64], out_name_word2);
                    check_field("out_name_word3", exp_r.ent.name[63:0], out_name_word3);
                    check_field("out_size", 64'(exp_r.ent.size), 64'(out_size));
                    check_field("out_mtime", 64'(exp_r.ent.mtime), 64'(out_mtime));
                    check_field("out_is_directory", 64'(exp_r.ent.dir),
                                64'(out_is_directory));
                    check_field("out_last", 64'(exp_r.last), 64'(out_last));
                    check_field("overflow", 64'(exp_r.ovf), 64'(overflow));
                    results_checked++;
                    if (exp_r.ovf)
                    begin
                        overflow_results++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (held.size() < MAX_ENTRIES)
                begin
                    ent.name  = trim_name({name_word0, name_word1, name_word2, name_word3});
                    ent.size  = entry_size;
                    ent.mtime = entry_mtime;
                    ent.dir   = is_directory;
                    held.push_back(ent);
                end
                else
                begin
                    // drop: store is full
                    drop_seen = 1'b1;
                end
                if (last_entry)
                begin
                    release_set();
                end
            end
            pending_results = sorted_q.size();
        end
    end

endmodule

@@ bench/tb_directory_entry_sorter_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Directory entry sorter testbench
// Sends record sets under changing sort settings, with random gaps on both
// channels, and lets the result checker judge every sorted record.
// ---------------------------------------------------------------------------
module tb_directory_entry_sorter_unit;
    import des_pkg::*;

    localparam int TARGET_ITEMS   = 410;
    localparam int IDLE_PCT       = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    localparam logic [1:0]           KEY_NONE     = 2'd3;
    localparam logic [1:0]           GROUP_MIXED  = 2'd0;
    localparam logic [1:0]           GROUP_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [NUM_W-1:0]  size;
        logic [NUM_W-1:0]  mtime;
        logic              dir;
    } entry_req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [63:0]           name_word0;
    logic [63:0]           name_word1;
    logic [63:0]           name_word2;
    logic [63:0]           name_word3;
    logic [NUM_W-1:0]      entry_size;
    logic [NUM_W-1:0]      entry_mtime;
    logic                  is_directory;
    logic                  last_entry;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [63:0]           out_name_word0;
    logic [63:0]           out_name_word1;
    logic [63:0]           out_name_word2;
    logic [63:0]           out_name_word3;
    logic [NUM_W-1:0]      out_size;
    logic [NUM_W-1:0]      out_mtime;
    logic                  out_is_directory;
    logic                  out_last;
    logic                  overflow;

    int fail_count;
    int pending_results;
    int results_checked;
    int overflow_results;
    int items_sent   = 0;
    int sets_sent    = 0;
    int quiet_cycles = 0;
    bit steady       = 1'b0;

    directory_entry_sorter_unit DUT (.*);

    des_result_checker result_check (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Count cycles with no request moving on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [NUM_W-1:0] rand_count();
        logic [63:0] raw;
        int          pick;
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            return NUM_W'($urandom_range(0, 3));
        end
        if (pick == 3)
        begin
            return {NUM_W{1'($urandom_range(0, 1))}};
        end
        return raw[NUM_W-1:0];
    endfunction

    function automatic logic [NAME_W-1:0] rand_name();
        logic [NAME_W-1:0] nm;
        int                pick;
        int                len;
        nm   = {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            // short names over a tiny alphabet: ties and shared prefixes
            len = $urandom_range(1, 4);
            if ($urandom_range(0, 1) == 1)
            begin
                nm = '0;
            end
            for (int b = 0; b <= len; b++)
            begin
                nm[NAME_W - 1 - 8 * b -: 8] = (b == len) ? 8'h00
                                              : 8'h61 + 8'($urandom_range(0, 2));
            end
        end
        else if (pick < 5)
        begin
            // terminator somewhere, junk behind it
            len = $urandom_range(0, NAME_W / 8 - 1);
            nm[NAME_W - 1 - 8 * len -: 8] = 8'h00;
        end
        else if (pick == 5)
        begin
            nm = {NAME_W{1'($urandom_range(0, 1))}};
        end
        return nm;
    endfunction

    function automatic entry_req_t make_entry(input logic [NAME_W-1:0] nm,
                                              input logic [NUM_W-1:0] sz,
                                              input logic [NUM_W-1:0] mt,
                                              input logic dir);
        entry_req_t e;
        e.name  = nm;
        e.size  = sz;
        e.mtime = mt;
        e.dir   = dir;
        return e;
    endfunction

    function automatic entry_req_t rand_entry();
        return make_entry(rand_name(), rand_count(), rand_count(), 1'($urandom_range(0, 1)));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_entry(input entry_req_t e, input logic last);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        name_word0   <= e.name[255:192];
        name_word1   <= e.name[191:128];
        name_word2   <= e.name[127:64];
        name_word3   <= e.name[63:0];
        entry_size   <= e.size;
        entry_mtime  <= e.mtime;
        is_directory <= e.dir;
        last_entry   <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (last)
        begin
            sets_sent++;
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_sort_mode(input logic [1:0] key, input logic [1:0] desc,
                                   input logic [1:0] group, input bit touch_spare);
        cfg_write <= 1'b1;
        cfg_index <= REG_SORT_KEY;
        cfg_data  <= key;
        @(negedge clk);
        cfg_index <= REG_DESCENDING;
        cfg_data  <= desc;
        @(negedge clk);
        cfg_index <= REG_DIR_GROUPING;
        cfg_data  <= group;
        @(negedge clk);
        if (touch_spare)
        begin
            cfg_index <= REG_SPARE;
            cfg_data  <= 2'($urandom_range(0, 3));
            @(negedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        logic [NUM_W-1:0]  top_num;
        logic [NAME_W-1:0] short_ab;
        int                set_no;
        int                set_len;
        top_num      = '1;
        short_ab     = {64'h6162_0000_0000_0000, 192'h0};
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        name_word0   = '0;
        name_word1   = '0;
        name_word2   = '0;
        name_word3   = '0;
        entry_size   = '0;
        entry_mtime  = '0;
        is_directory = 1'b0;
        last_entry   = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Name order, mixed: extremes, early terminator, tie on trimmed name.
        apply_sort_mode(KEY_NAME, 2'd0, GROUP_MIXED, 1'b0);
        send_entry(make_entry('1, top_num, '0, 1'b1), 1'b0);
        send_entry(make_entry('0, '0, top_num, 1'b0), 1'b0);
        send_entry(make_entry({64'h6162_0063_6465_6667, {192{1'b1}}}, 5, 5, 1'b0), 1'b0);
        send_entry(make_entry(short_ab, 7, 1, 1'b1), 1'b0);
        send_entry(make_entry({64'h6162_6300_0000_0000, 192'h0}, 5, 5, 1'b0), 1'b0);
        send_entry(make_entry({NAME_W / 8{8'h80}}, 1, top_num, 1'b0), 1'b1);

        // Size descending, directories first, with equal sizes.
        wait_drained();
        apply_sort_mode(KEY_SIZE, 2'd1, GROUP_DIRS_FIRST, 1'b0);
        send_entry(make_entry(rand_name(), 10, rand_count(), 1'b0), 1'b0);
        send_entry(make_entry(rand_name(), 10, rand_count(), 1'b1), 1'b0);
        send_entry(make_entry(rand_name(), top_num, rand_count(), 1'b0), 1'b0);
        send_entry(make_entry(rand_name(), 0, rand_count(), 1'b1), 1'b0);
        send_entry(make_entry(rand_name(), 10, rand_count(), 1'b0), 1'b1);

        // Time ascending, directories last.
        wait_drained();
        apply_sort_mode(KEY_MTIME, 2'd0, GROUP_DIRS_LAST, 1'b0);
        send_entry(make_entry(rand_name(), rand_count(), 3, 1'b1), 1'b0);
        send_entry(make_entry(rand_name(), rand_count(), 3, 1'b0), 1'b0);
        send_entry(make_entry(rand_name(), rand_count(), 0, 1'b1), 1'b0);
        send_entry(make_entry(rand_name(), rand_count(), top_num, 1'b0), 1'b0);
        send_entry(make_entry(rand_name(), rand_count(), 1, 1'b0), 1'b1);

        // Unused key and grouping codes: arrival order must hold.
        wait_drained();
        apply_sort_mode(KEY_NONE, 2'b10, GROUP_SPARE, 1'b1);
        send_entry(make_entry(rand_name(), 9, 9, 1'b1), 1'b0);
        send_entry(make_entry(rand_name(), 2, 2, 1'b0), 1'b0);
        send_entry(make_entry(rand_name(), top_num, 0, 1'b1), 1'b0);
        send_entry(make_entry(rand_name(), 0, top_num, 1'b0), 1'b1);

        // Single record set.
        wait_drained();
        apply_sort_mode(KEY_NAME, 2'd1, GROUP_DIRS_FIRST, 1'b0);
        send_entry(rand_entry(), 1'b1);

        set_no = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            if (set_no == 2)
            begin
                set_len = MAX_ENTRIES;
            end
            else if (set_no == 5)
            begin
                // last record itself is dropped
                set_len = MAX_ENTRIES + 3;
            end
            else if (set_no == 11)
            begin
                set_len = MAX_ENTRIES + 1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                set_len = $urandom_range(9, 20);
            end
            else
            begin
                set_len = $urandom_range(1, 8);
            end
            steady = (set_no >= 8 && set_no < 14);
            if (set_no % 2 == 0 || $urandom_range(0, 3) == 0)
            begin
                wait_drained();
                apply_sort_mode(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                2'($urandom_range(0, 3)), $urandom_range(0, 5) == 0);
            end
            for (int k = 0; k < set_len; k++)
            begin
                send_entry(rand_entry(), k == set_len - 1);
            end
            set_no++;
        end
        steady = 1'b0;

        wait_drained();
        repeat (2 * MAX_ENTRIES + 8) @(negedge clk);

        $display("Sent %0d records in %0d sets under changing key, direction and grouping.",
                 items_sent, sets_sent);
        $display("Checked %0d sorted records, %0d of them from sets that ran past capacity.",
                 results_checked, overflow_results);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/des_pkg.sv
sv/des_cell.sv
sv/directory_entry_sorter_unit.sv
sv/des_checker.sv
bench/des_result_checker.sv
bench/tb_directory_entry_sorter_unit.sv
